@@ src/nwcr_pkg.sv @@
// Shared types and constants for the n-way coincidence release block.
package nwcr_pkg;

  localparam int NODE_W      = 10;
  localparam int STEP_W      = 16;
  localparam int SAMPLE_W    = 32;
  localparam int NREQ_W      = 5;
  localparam int HIT_CNT_W   = 11;
  localparam logic [HIT_CNT_W-1:0] HIT_CNT_MAX = 11'd2047;

  // Hit map is kept as rows of bits; the low node bits select the bit.
  localparam int HIT_BIT_AW  = 5;
  localparam int HIT_ROW_W   = 1 << HIT_BIT_AW;
  localparam int HIT_ROW_AW  = NODE_W - HIT_BIT_AW;
  localparam int HIT_ROWS    = 1 << HIT_ROW_AW;

  localparam int PEND_DEPTH  = 32;
  localparam int PEND_AW     = 5;
  localparam int PEND_CNT_W  = 6;

  localparam int FIFO_DEPTH  = 4;
  localparam int FIFO_AW     = 2;
  localparam int FIFO_CNT_W  = 3;

  localparam int CFG_IDX_W   = 1;
  localparam logic [CFG_IDX_W-1:0] CFG_QUALITY_THRESHOLD = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_NODES_REQUIRED    = 1'd1;

  localparam logic OP_MARK   = 1'b0;
  localparam logic OP_SAMPLE = 1'b1;

  typedef struct packed {
    logic                 valid;
    logic [CFG_IDX_W-1:0] index;
    logic [SAMPLE_W-1:0]  data;
  } cfg_wr_t;

  typedef struct packed {
    logic              op;
    logic [NODE_W-1:0] node;
    logic [STEP_W-1:0] step;
  } item_t;

  typedef struct packed {
    logic [NODE_W-1:0] node;
    logic [STEP_W-1:0] step;
    logic              last;
    logic              ovf;
  } result_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_LOOK,
    BK_FRD,
    BK_FOUT
  } back_state_t;

endpackage

@@ src/nwcr_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module nwcr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ src/nwcr_front.sv @@
// Front end: holds the quality threshold, classifies samples, drops non-hits.
module nwcr_front (
  input  logic                             clk,
  input  logic                             rst_n,
  input  nwcr_pkg::cfg_wr_t                cfg_wr,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic                             in_op,
  input  logic [nwcr_pkg::NODE_W-1:0]      in_node_index,
  input  logic [nwcr_pkg::STEP_W-1:0]      in_time_step,
  input  logic signed [nwcr_pkg::SAMPLE_W-1:0] in_sample,
  input  logic                             fifo_full,
  output logic                             fifo_push,
  output nwcr_pkg::item_t                  fifo_item
);

  logic signed [nwcr_pkg::SAMPLE_W-1:0] thr_r;
  logic                                 qualifies;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r <= '0;
    end else if (cfg_wr.valid && (cfg_wr.index == nwcr_pkg::CFG_QUALITY_THRESHOLD)) begin
      thr_r <= cfg_wr.data;
    end
  end

  // Sample must be above zero and above the threshold.
  assign qualifies = (in_sample > 0) && (in_sample > thr_r);

  assign in_stall       = fifo_full;
  assign fifo_push      = in_valid && !fifo_full &&
                          ((in_op == nwcr_pkg::OP_MARK) || qualifies);
  assign fifo_item.op   = in_op;
  assign fifo_item.node = in_node_index;
  assign fifo_item.step = in_time_step;

endmodule

@@ src/nwcr_fifo.sv @@
// Short queue of classified items between the front and back ends.
module nwcr_fifo (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  nwcr_pkg::item_t push_item,
  output logic            full,
  input  logic            pop,
  output logic            not_empty,
  output nwcr_pkg::item_t head
);

  nwcr_pkg::item_t                     entries_r [nwcr_pkg::FIFO_DEPTH];
  logic [nwcr_pkg::FIFO_AW-1:0]        wr_ptr_r, rd_ptr_r;
  logic [nwcr_pkg::FIFO_CNT_W-1:0]     cnt_r, cnt_nxt;
  logic                                do_push, do_pop;

  assign full      = (cnt_r == nwcr_pkg::FIFO_CNT_W'(nwcr_pkg::FIFO_DEPTH));
  assign not_empty = (cnt_r != '0);
  assign head      = entries_r[rd_ptr_r];
  assign do_push   = push && !full;
  assign do_pop    = pop && not_empty;

  always_comb begin
    cnt_nxt = cnt_r;
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      cnt_r <= cnt_nxt;
      if (do_push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries_r[wr_ptr_r] <= push_item;
    end
  end

endmodule

@@ src/nwcr_back.sv @@
// Back end: hit map update, hit counting, pending list and release flush.
module nwcr_back (
  input  logic                    clk,
  input  logic                    rst_n,
  input  nwcr_pkg::cfg_wr_t       cfg_wr,
  input  logic                    item_vld,
  input  nwcr_pkg::item_t         item,
  output logic                    item_pop,
  output logic                    out_valid,
  input  logic                    out_stall,
  output nwcr_pkg::result_t       out_res
);

  nwcr_pkg::back_state_t                 state_r, state_nxt;
  nwcr_pkg::item_t                       cur_r;
  logic [nwcr_pkg::NREQ_W-1:0]           nreq_r;
  logic [nwcr_pkg::HIT_CNT_W-1:0]        hit_cnt_r, cnt_inc;
  logic [nwcr_pkg::PEND_CNT_W-1:0]       pcnt_r, fidx_r;
  logic                                  ovf_r;
  logic [nwcr_pkg::HIT_ROWS-1:0]         row_vld_r;
  logic                                  out_vld_r;
  nwcr_pkg::result_t                     out_res_r;

  logic                                  out_free;
  logic [nwcr_pkg::HIT_ROW_AW-1:0]       cur_row;
  logic [nwcr_pkg::HIT_BIT_AW-1:0]       cur_bit;
  logic [nwcr_pkg::HIT_ROW_W-1:0]        hit_rdata, row_cur, row_new;
  logic                                  already_hit, releases, pend_full, flush_last;
  logic [nwcr_pkg::NODE_W-1:0]           pend_rdata;

  // Control strobes from the output decode.
  logic hit_re, hit_we, pend_we, pend_re, enq, cnt_upd, out_load_node, out_load_pend;

  assign out_free    = !out_vld_r || !out_stall;
  assign cur_row     = cur_r.node[nwcr_pkg::NODE_W-1:nwcr_pkg::HIT_BIT_AW];
  assign cur_bit     = cur_r.node[nwcr_pkg::HIT_BIT_AW-1:0];
  assign row_cur     = row_vld_r[cur_row] ? hit_rdata : '0;
  assign row_new     = row_cur | (nwcr_pkg::HIT_ROW_W'(1) << cur_bit);
  assign already_hit = row_cur[cur_bit];
  assign cnt_inc     = (hit_cnt_r == nwcr_pkg::HIT_CNT_MAX) ? hit_cnt_r : hit_cnt_r + 1'b1;
  assign releases    = cnt_inc > nwcr_pkg::HIT_CNT_W'(nreq_r);
  assign pend_full   = (pcnt_r == nwcr_pkg::PEND_CNT_W'(nwcr_pkg::PEND_DEPTH));
  assign flush_last  = (nwcr_pkg::PEND_CNT_W'(fidx_r + 1'b1) == pcnt_r);

  nwcr_ram #(
    .WIDTH (nwcr_pkg::HIT_ROW_W),
    .DEPTH (nwcr_pkg::HIT_ROWS)
  ) u_hit_ram (
    .clk   (clk),
    .we    (hit_we),
    .waddr (cur_row),
    .wdata (row_new),
    .re    (hit_re),
    .raddr (item.node[nwcr_pkg::NODE_W-1:nwcr_pkg::HIT_BIT_AW]),
    .rdata (hit_rdata)
  );

  nwcr_ram #(
    .WIDTH (nwcr_pkg::NODE_W),
    .DEPTH (nwcr_pkg::PEND_DEPTH)
  ) u_pend_ram (
    .clk   (clk),
    .we    (pend_we),
    .waddr (pcnt_r[nwcr_pkg::PEND_AW-1:0]),
    .wdata (cur_r.node),
    .re    (pend_re),
    .raddr (fidx_r[nwcr_pkg::PEND_AW-1:0]),
    .rdata (pend_rdata)
  );

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      nwcr_pkg::BK_IDLE: begin
        if (item_vld) begin
          state_nxt = nwcr_pkg::BK_LOOK;
        end
      end
      nwcr_pkg::BK_LOOK: begin
        if (out_free) begin
          if ((cur_r.op == nwcr_pkg::OP_SAMPLE) && !already_hit && releases &&
              (pcnt_r != '0)) begin
            state_nxt = nwcr_pkg::BK_FRD;
          end else begin
            state_nxt = nwcr_pkg::BK_IDLE;
          end
        end
      end
      nwcr_pkg::BK_FRD: begin
        state_nxt = nwcr_pkg::BK_FOUT;
      end
      nwcr_pkg::BK_FOUT: begin
        if (out_free) begin
          state_nxt = flush_last ? nwcr_pkg::BK_IDLE : nwcr_pkg::BK_FRD;
        end
      end
      default: state_nxt = nwcr_pkg::BK_IDLE;
    endcase
  end

  // Output decode.
  always_comb begin
    item_pop      = 1'b0;
    hit_re        = 1'b0;
    hit_we        = 1'b0;
    enq           = 1'b0;
    cnt_upd       = 1'b0;
    pend_re       = 1'b0;
    out_load_node = 1'b0;
    out_load_pend = 1'b0;
    unique case (state_r)
      nwcr_pkg::BK_IDLE: begin
        item_pop = item_vld;
        hit_re   = item_vld;
      end
      nwcr_pkg::BK_LOOK: begin
        if (out_free) begin
          hit_we = 1'b1;
          if (cur_r.op == nwcr_pkg::OP_MARK) begin
            enq = 1'b1;
          end else if (!already_hit) begin
            cnt_upd       = 1'b1;
            out_load_node = releases;
            enq           = !releases;
          end
        end
      end
      nwcr_pkg::BK_FRD: begin
        pend_re = 1'b1;
      end
      nwcr_pkg::BK_FOUT: begin
        out_load_pend = out_free;
      end
      default: ;
    endcase
  end

  assign pend_we = enq && !pend_full;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= nwcr_pkg::BK_IDLE;
      nreq_r    <= nwcr_pkg::NREQ_W'(1);
      hit_cnt_r <= nwcr_pkg::HIT_CNT_W'(1);
      pcnt_r    <= '0;
      fidx_r    <= '0;
      ovf_r     <= 1'b0;
      row_vld_r <= '0;
      out_vld_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_wr.valid && (cfg_wr.index == nwcr_pkg::CFG_NODES_REQUIRED)) begin
        nreq_r <= cfg_wr.data[nwcr_pkg::NREQ_W-1:0];
      end
      if (hit_we) begin
        row_vld_r[cur_row] <= 1'b1;
      end
      if (cnt_upd) begin
        hit_cnt_r <= cnt_inc;
      end
      // Queue the node, or flag the drop when the list is full.
      if (enq) begin
        if (pend_full) begin
          ovf_r <= 1'b1;
        end else begin
          pcnt_r <= pcnt_r + 1'b1;
        end
      end
      if (out_load_node) begin
        fidx_r <= '0;
      end else if (out_load_pend) begin
        if (flush_last) begin
          pcnt_r <= '0;
        end else begin
          fidx_r <= fidx_r + 1'b1;
        end
      end
      if (out_load_node || out_load_pend) begin
        out_vld_r <= 1'b1;
      end else if (!out_stall) begin
        out_vld_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (item_pop) begin
      cur_r <= item;
    end
    if (out_load_node) begin
      out_res_r.node <= cur_r.node;
      out_res_r.step <= cur_r.step;
      out_res_r.last <= (pcnt_r == '0);
      out_res_r.ovf  <= ovf_r;
    end else if (out_load_pend) begin
      out_res_r.node <= pend_rdata;
      out_res_r.step <= cur_r.step;
      out_res_r.last <= flush_last;
      out_res_r.ovf  <= ovf_r;
    end
  end

  assign out_valid = out_vld_r;
  assign out_res   = out_res_r;

  a_pcnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    pcnt_r <= nwcr_pkg::PEND_CNT_W'(nwcr_pkg::PEND_DEPTH))
    else $error("pending count beyond list depth");

  a_flush_idx: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == nwcr_pkg::BK_FOUT) |-> (fidx_r < pcnt_r))
    else $error("flush index past pending count");

  a_hit_cnt_nz: assert property (@(posedge clk) disable iff (!rst_n)
    hit_cnt_r != '0)
    else $error("hit count wrapped to zero");

  a_flush_entry: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == nwcr_pkg::BK_FRD) |->
      ($past(state_r) == nwcr_pkg::BK_LOOK) || ($past(state_r) == nwcr_pkg::BK_FOUT))
    else $error("flush started without a release");

endmodule

@@ src/n_way_coincidence_release.sv @@
// Top level of the n-way coincidence release block.
// Path: an accepted mark or above-threshold sample goes through the queue into the back
//   end's current-item register; a releasing hit then sets out_valid via the output register.
// Flow: the front takes one transaction per cycle while the queue is not full; each mark or
//   above-threshold sample takes a back-end hit map read, then write; a release adds a pending
//   list read, then output load, per pending node; out_stall stretches both.
// Reset (synchronous, rst_n low): threshold 0, nodes_required 1, hit count 1, pending list
//   empty, overflow clear, hit map row valid bits clear; no clearing pass is needed.
module n_way_coincidence_release (
  input  logic                                 clk,
  input  logic                                 rst_n,
  // Configuration write channel
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [nwcr_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [nwcr_pkg::SAMPLE_W-1:0]        cfg_data,
  // Input channel
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic                                 in_op,
  input  logic [nwcr_pkg::NODE_W-1:0]          in_node_index,
  input  logic [nwcr_pkg::STEP_W-1:0]          in_time_step,
  input  logic signed [nwcr_pkg::SAMPLE_W-1:0] in_sample,
  // Result channel
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic [nwcr_pkg::NODE_W-1:0]          out_detected_node,
  output logic [nwcr_pkg::STEP_W-1:0]          out_detect_step,
  output logic                                 out_last,
  output logic                                 out_overflowed
);

  nwcr_pkg::cfg_wr_t  cfg_wr;
  nwcr_pkg::item_t    push_item, head_item;
  nwcr_pkg::result_t  res;
  logic               fifo_full, fifo_push, fifo_not_empty, fifo_pop;

  // Configuration is always taken; the user must write only while the block is idle, which the block does not enforce.
  assign cfg_ready    = 1'b1;
  assign cfg_wr.valid = cfg_valid && cfg_ready;
  assign cfg_wr.index = cfg_index;
  assign cfg_wr.data  = cfg_data;

  // Front: classify each transaction, keep marks and above-threshold samples.
  nwcr_front u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_wr        (cfg_wr),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_op         (in_op),
    .in_node_index (in_node_index),
    .in_time_step  (in_time_step),
    .in_sample     (in_sample),
    .fifo_full     (fifo_full),
    .fifo_push     (fifo_push),
    .fifo_item     (push_item)
  );

  // Queue decouples the front from hit map updates and release flushes.
  nwcr_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (fifo_push),
    .push_item (push_item),
    .full      (fifo_full),
    .pop       (fifo_pop),
    .not_empty (fifo_not_empty),
    .head      (head_item)
  );

  // Back: hit map, hit count, pending list and the output register.
  nwcr_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_wr    (cfg_wr),
    .item_vld  (fifo_not_empty),
    .item      (head_item),
    .item_pop  (fifo_pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_res   (res)
  );

  assign out_detected_node = res.node;
  assign out_detect_step   = res.step;
  assign out_last          = res.last;
  assign out_overflowed    = res.ovf;

endmodule
